[rtl/oli_pkg.sv]
// shared types and codes for the ordered list block
// no dependencies; used by oli_seq and ordered_list_insert_delete
package oli_pkg;

   localparam int unsigned DEPTH_DEFAULT = 1024;
   localparam int unsigned WORD_W        = 32;
   localparam int unsigned COUNT_W       = 11;
   localparam int unsigned POS_W         = 10;

   localparam logic [COUNT_W-1:0] CAP_RESET = 11'd1024;

   // operation codes on req_mode
   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_DELETE = 2'd1;
   localparam logic [1:0] MODE_READ   = 2'd2;

   // result status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_INDEX = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_UNUSED    = 2'd3;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_SHIFT_UP,
      SEQ_PLACE,
      SEQ_SHIFT_DOWN,
      SEQ_READ_WAIT,
      SEQ_DONE
   } seq_state_type;

   typedef struct packed {
      logic [1:0]               status;
      logic [COUNT_W-1:0]       count;
      logic signed [WORD_W-1:0] value;
   } result_type;

endpackage

[rtl/ordered_list_insert_delete.sv]
// ordered list of signed words with insert, delete and read at an index
// throughput: one item at a time, set by one store read and one write per shifted entry
// store is a registered-read ram; it is never cleared and needs no clearing pass
// reset (synchronous, active high) empties the list and sets the capacity to 1024
// depends on oli_pkg, oli_seq, oli_ram
module ordered_list_insert_delete #(
   parameter int unsigned DEPTH = oli_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,

   // configuration: capacity limit register
   input  logic                              csr_wr_en,
   input  logic [oli_pkg::COUNT_W-1:0]       csr_wr_data,

   // request beats
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_mode,
   input  logic [oli_pkg::POS_W-1:0]         req_position,
   input  logic signed [oli_pkg::WORD_W-1:0] req_new_value,

   // response beats
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_status,
   output logic [oli_pkg::COUNT_W-1:0]       rsp_element_count,
   output logic signed [oli_pkg::WORD_W-1:0] rsp_read_value
);

   // capacity limit register
   logic [oli_pkg::COUNT_W-1:0] capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= oli_pkg::CAP_RESET;
      end else if (csr_wr_en) begin
         capacity_ff <= csr_wr_data;
      end
   end

   // sequencer with the list store
   logic                res_valid;
   logic                res_ready;
   oli_pkg::result_type res;

   oli_seq #(
      .DEPTH (DEPTH)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .capacity      (capacity_ff),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_position  (req_position),
      .req_new_value (req_new_value),
      .res_valid     (res_valid),
      .res_ready     (res_ready),
      .res           (res)
   );

   // output register: the sequencer hands over a finished beat whenever
   // the register is empty or is being drained this cycle
   logic                rsp_valid_ff, rsp_valid_in;
   oli_pkg::result_type rsp_data_ff, rsp_data_in;
   logic                load;

   assign res_ready = !rsp_valid_ff || !rsp_stall;
   assign load      = res_valid && res_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_data_ff.status;
   assign rsp_element_count = rsp_data_ff.count;
   assign rsp_read_value    = rsp_data_ff.value;

   // the list never holds more entries than the store
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_element_count) <= 32'(DEPTH)))
      else $error("element count beyond store depth");

   // a failed or non-read operation returns a zero word
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != oli_pkg::ST_OK) |-> (rsp_read_value == '0))
      else $error("nonzero read value with error status");

   // the sequencer is busy right after taking a request
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while previous one in flight");

   // the unused status code never appears
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status != oli_pkg::ST_UNUSED))
      else $error("reserved status code on response");

endmodule

[rtl/oli_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
module oli_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/oli_seq.sv]
// list sequencer: checks, entry shifting through the store, element count
// depends on oli_pkg and oli_ram
module oli_seq #(
   parameter int unsigned DEPTH = oli_pkg::DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [oli_pkg::COUNT_W-1:0]          capacity,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_mode,
   input  logic [oli_pkg::POS_W-1:0]            req_position,
   input  logic signed [oli_pkg::WORD_W-1:0]    req_new_value,
   output logic                                 res_valid,
   input  logic                                 res_ready,
   output oli_pkg::result_type                  res
);

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned XW = (AW > oli_pkg::COUNT_W) ? AW : oli_pkg::COUNT_W;
   localparam int unsigned CW = oli_pkg::COUNT_W;

   function automatic logic [AW-1:0] to_addr(input logic [CW-1:0] idx);
      logic [XW-1:0] wide;
      wide = XW'(idx);
      return wide[AW-1:0];
   endfunction

   oli_pkg::seq_state_type state_ff, state_in;

   logic [CW-1:0]                    count_ff, count_in;
   logic [oli_pkg::POS_W-1:0]        pos_ff, pos_in;
   logic [oli_pkg::WORD_W-1:0]       val_ff, val_in;
   logic [CW-1:0]                    idx_ff, idx_in;
   logic                             pend_ff, pend_in;
   logic [CW-1:0]                    pend_idx_ff, pend_idx_in;
   logic [1:0]                       status_ff, status_in;
   logic [oli_pkg::WORD_W-1:0]       rd_value_ff, rd_value_in;

   logic                             ram_rd_en;
   logic [CW-1:0]                    ram_rd_idx;
   logic                             ram_wr_en;
   logic [CW-1:0]                    ram_wr_idx;
   logic [oli_pkg::WORD_W-1:0]       ram_wr_data;
   logic [oli_pkg::WORD_W-1:0]       ram_rd_data;

   logic [CW-1:0]                    pos_ext;
   logic [CW-1:0]                    req_pos_ext;
   logic                             list_full;

   assign pos_ext     = CW'(pos_ff);
   assign req_pos_ext = CW'(req_position);
   assign list_full   = (count_ff >= capacity) || (32'(count_ff) >= 32'(DEPTH));

   oli_ram #(
      .WIDTH (oli_pkg::WORD_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (to_addr(ram_wr_idx)),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (to_addr(ram_rd_idx)),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= oli_pkg::SEQ_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      val_ff      <= val_in;
      idx_ff      <= idx_in;
      pend_idx_ff <= pend_idx_in;
      status_ff   <= status_in;
      rd_value_ff <= rd_value_in;
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      pos_in      = pos_ff;
      val_in      = val_ff;
      idx_in      = idx_ff;
      pend_in     = pend_ff;
      pend_idx_in = pend_idx_ff;
      status_in   = status_ff;
      rd_value_in = rd_value_ff;

      req_stall   = 1'b1;
      res_valid   = 1'b0;
      ram_rd_en   = 1'b0;
      ram_rd_idx  = idx_ff;
      // a read issued last cycle lands in its shifted slot now
      ram_wr_en   = pend_ff;
      ram_wr_idx  = pend_idx_ff;
      ram_wr_data = ram_rd_data;

      case (state_ff)
         oli_pkg::SEQ_IDLE: begin
            req_stall = 1'b0;
            pend_in   = 1'b0;
            if (req_valid) begin
               pos_in      = req_position;
               val_in      = req_new_value;
               rd_value_in = '0;
               status_in   = oli_pkg::ST_OK;
               state_in    = oli_pkg::SEQ_DONE;
               case (req_mode)
                  oli_pkg::MODE_INSERT: begin
                     if (req_pos_ext > count_ff) begin
                        status_in = oli_pkg::ST_BAD_INDEX;
                     end else if (list_full) begin
                        status_in = oli_pkg::ST_FULL;
                     end else begin
                        idx_in   = count_ff;
                        state_in = oli_pkg::SEQ_SHIFT_UP;
                     end
                  end
                  oli_pkg::MODE_DELETE: begin
                     if (req_pos_ext >= count_ff) begin
                        status_in = oli_pkg::ST_BAD_INDEX;
                     end else begin
                        idx_in   = req_pos_ext;
                        state_in = oli_pkg::SEQ_SHIFT_DOWN;
                     end
                  end
                  oli_pkg::MODE_READ: begin
                     if (req_pos_ext >= count_ff) begin
                        status_in = oli_pkg::ST_BAD_INDEX;
                     end else begin
                        ram_rd_en  = 1'b1;
                        ram_rd_idx = req_pos_ext;
                        state_in   = oli_pkg::SEQ_READ_WAIT;
                     end
                  end
                  default: begin
                     status_in = oli_pkg::ST_OK;
                  end
               endcase
            end
         end

         oli_pkg::SEQ_SHIFT_UP: begin
            // walk down from the tail, entry i-1 moves to i
            if (idx_ff > pos_ext) begin
               ram_rd_en   = 1'b1;
               ram_rd_idx  = idx_ff - 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = idx_ff;
               idx_in      = idx_ff - 1'b1;
            end else begin
               pend_in  = 1'b0;
               state_in = oli_pkg::SEQ_PLACE;
            end
         end

         oli_pkg::SEQ_PLACE: begin
            ram_wr_en   = 1'b1;
            ram_wr_idx  = pos_ext;
            ram_wr_data = val_ff;
            count_in    = count_ff + 1'b1;
            state_in    = oli_pkg::SEQ_DONE;
         end

         oli_pkg::SEQ_SHIFT_DOWN: begin
            // walk up from the hole, entry i+1 moves to i
            if ((12'(idx_ff) + 12'd1) < 12'(count_ff)) begin
               ram_rd_en   = 1'b1;
               ram_rd_idx  = idx_ff + 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = idx_ff;
               idx_in      = idx_ff + 1'b1;
            end else begin
               pend_in  = 1'b0;
               count_in = count_ff - 1'b1;
               state_in = oli_pkg::SEQ_DONE;
            end
         end

         oli_pkg::SEQ_READ_WAIT: begin
            rd_value_in = ram_rd_data;
            state_in    = oli_pkg::SEQ_DONE;
         end

         oli_pkg::SEQ_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = oli_pkg::SEQ_IDLE;
            end
         end

         default: begin
            state_in = oli_pkg::SEQ_IDLE;
         end
      endcase
   end

   assign res.status = status_ff;
   assign res.count  = count_ff;
   assign res.value  = rd_value_ff;

endmodule
